/* rtl/core/mlep_pkg.sv */
// ----------------------------------------------------------------------------
// mlep_pkg
// Shared types and constants of the event stream parser: parse phases,
// event kinds, command nibbles and the result record.
// ----------------------------------------------------------------------------
package mlep_pkg;

    localparam int TICK_WIDTH_DEFAULT = 32;
    localparam int DELTA_WIDTH        = 28;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    localparam logic [7:0] STATUS_FLAG   = 8'h80;
    localparam logic [3:0] BYTES_MAX     = 4'hF;

    localparam logic [3:0] CMD_NOTE_OFF  = 4'h8;
    localparam logic [3:0] CMD_NOTE_ON   = 4'h9;
    localparam logic [3:0] CMD_PROGRAM   = 4'hC;
    localparam logic [3:0] CMD_STOP_D    = 4'hD;
    localparam logic [3:0] CMD_BEND      = 4'hE;
    localparam logic [3:0] CMD_END_TRACK = 4'hF;

    typedef enum logic [5:0] {
        PH_DELTA  = 6'b000001,
        PH_STATUS = 6'b000010,
        PH_DATA1  = 6'b000100,
        PH_DATA2  = 6'b001000,
        PH_ZERO1  = 6'b010000,
        PH_ZERO2  = 6'b100000
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NOTE_OFF  = 3'd0,
        KIND_NOTE_ON   = 3'd1,
        KIND_UNKNOWN   = 3'd2,
        KIND_PROGRAM   = 3'd3,
        KIND_BEND      = 3'd4,
        KIND_END_TRACK = 3'd5,
        KIND_DATA_END  = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  channel;
        logic [7:0]  first_value;
        logic [7:0]  second_value;
        logic [31:0] tick_time;
        logic [3:0]  event_bytes;
        logic        last_of_run;
    } event_t;

endpackage

/* rtl/core/mlep_parser.sv */
// ----------------------------------------------------------------------------
// mlep_parser
// Parse state and single-pass decode of one registered input byte into up
// to two event records.
// ----------------------------------------------------------------------------
module mlep_parser #(
    parameter int TICK_WIDTH = mlep_pkg::TICK_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        data_byte,
    input  logic              final_byte,
    output mlep_pkg::event_t  res_first,
    output mlep_pkg::event_t  res_second,
    output logic [1:0]        res_count
);
    import mlep_pkg::*;

    phase_t                  phase_reg,   phase_next;
    logic                    skip_reg,    skip_next;
    logic [DELTA_WIDTH-1:0]  accum_reg,   accum_next;
    logic [7:0]              status_reg,  status_next;
    logic [7:0]              key_reg,     key_next;
    logic [TICK_WIDTH-1:0]   tick_reg,    tick_next;
    logic [3:0]              bcount_reg,  bcount_next;
    logic                    stopped_reg, stopped_next;

    logic [63:0]             tick_ext;
    logic [3:0]              bc_inc;
    logic [DELTA_WIDTH-1:0]  accum_shift;
    logic                    st_low;
    logic [7:0]              st_value;
    logic                    st_stop;
    logic [3:0]              st_bc;
    event_t                  ev_base;
    event_t                  st_event;
    logic                    do_status;

    assign tick_ext    = 64'(tick_reg);
    assign bc_inc      = (bcount_reg == BYTES_MAX) ? bcount_reg : bcount_reg + 4'd1;
    assign accum_shift = {accum_reg[DELTA_WIDTH-8:0], data_byte[6:0]};

    // Status decode is shared by the status phase and by the held zero status
    // case, where the byte after two zeros is taken as a fresh status.
    assign st_low   = ~data_byte[7];
    assign st_value = data_byte | STATUS_FLAG;
    assign st_stop  = (st_value[7:4] == CMD_END_TRACK) || (st_value[7:4] == CMD_STOP_D);
    assign st_bc    = (phase_reg == PH_ZERO2) ? 4'd1 : bc_inc;

    always_comb
    begin
        ev_base              = '0;
        ev_base.tick_time    = tick_ext[31:0];
        ev_base.event_bytes  = bc_inc;

        st_event             = ev_base;
        st_event.kind        = (st_value[7:4] == CMD_END_TRACK) ? KIND_END_TRACK
                                                                 : KIND_UNKNOWN;
        st_event.channel     = st_value[3:0];
        st_event.event_bytes = st_bc;
    end

    always_comb
    begin
        phase_next   = phase_reg;
        skip_next    = skip_reg;
        accum_next   = accum_reg;
        status_next  = status_reg;
        key_next     = key_reg;
        tick_next    = tick_reg;
        bcount_next  = bcount_reg;
        stopped_next = stopped_reg;
        res_first    = ev_base;
        res_second   = ev_base;
        res_count    = 2'd0;
        do_status    = 1'b0;

        if (fire && !stopped_reg)
        begin
            unique case (phase_reg)
                PH_DELTA:
                begin
                    bcount_next = bc_inc;
                    if (!data_byte[7])
                    begin
                        tick_next   = tick_reg + TICK_WIDTH'(accum_shift);
                        accum_next  = '0;
                        phase_next  = PH_STATUS;
                    end
                    else
                    begin
                        accum_next = accum_shift;
                    end
                end
                PH_STATUS:
                begin
                    do_status = 1'b1;
                end
                PH_DATA1:
                begin
                    res_first.channel = status_reg[3:0];
                    if (status_reg[7:4] == CMD_NOTE_ON)
                    begin
                        bcount_next = bc_inc;
                        key_next    = data_byte;
                        phase_next  = PH_DATA2;
                    end
                    else
                    begin
                        res_count = 2'd1;
                        unique case (status_reg[7:4])
                            CMD_NOTE_OFF:
                            begin
                                res_first.kind        = KIND_NOTE_OFF;
                                res_first.first_value = data_byte;
                            end
                            CMD_PROGRAM:
                            begin
                                res_first.kind        = KIND_PROGRAM;
                                res_first.first_value = data_byte;
                            end
                            CMD_BEND:
                            begin
                                res_first.kind        = KIND_BEND;
                                res_first.first_value = {1'b0, data_byte[7:1]};
                            end
                            default:
                            begin
                                res_first.kind = KIND_UNKNOWN;
                            end
                        endcase
                        bcount_next = '0;
                        accum_next  = '0;
                        phase_next  = skip_reg ? PH_STATUS : PH_DELTA;
                    end
                end
                PH_DATA2:
                begin
                    res_count              = 2'd1;
                    res_first.kind         = KIND_NOTE_ON;
                    res_first.channel      = status_reg[3:0];
                    res_first.first_value  = key_reg;
                    res_first.second_value = data_byte;
                    bcount_next            = '0;
                    accum_next             = '0;
                    phase_next             = skip_reg ? PH_STATUS : PH_DELTA;
                end
                PH_ZERO1:
                begin
                    if (data_byte != 8'd0)
                    begin
                        res_count             = 2'd1;
                        res_first.kind        = KIND_NOTE_OFF;
                        res_first.first_value = data_byte;
                        bcount_next           = '0;
                        accum_next            = '0;
                        phase_next            = skip_reg ? PH_STATUS : PH_DELTA;
                    end
                    else
                    begin
                        bcount_next = bc_inc;
                        phase_next  = PH_ZERO2;
                    end
                end
                PH_ZERO2:
                begin
                    res_count = 2'd1;
                    if (data_byte == 8'd0)
                    begin
                        res_first.kind = KIND_DATA_END;
                        stopped_next   = 1'b1;
                    end
                    else
                    begin
                        // Two zero bytes were a note off of key zero; this byte
                        // opens the next event, and its size excludes it.
                        res_first.kind        = KIND_NOTE_OFF;
                        res_first.event_bytes = bcount_reg;
                        accum_next            = '0;
                        phase_next            = skip_reg ? PH_STATUS : PH_DELTA;
                        do_status             = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_STATUS;
                end
            endcase

            if (do_status)
            begin
                bcount_next = st_bc;
                skip_next   = st_low;
                if (data_byte == 8'd0)
                begin
                    status_next = STATUS_FLAG;
                    phase_next  = PH_ZERO1;
                end
                else
                begin
                    status_next = st_value;
                    if (st_stop)
                    begin
                        stopped_next = 1'b1;
                        if (res_count == 2'd0)
                        begin
                            res_first = st_event;
                        end
                        else
                        begin
                            res_second = st_event;
                        end
                        res_count = res_count + 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_DATA1;
                    end
                end
            end

            if (final_byte)
            begin
                stopped_next = 1'b1;
            end
        end

        if (res_count == 2'd1)
        begin
            res_first.last_of_run = 1'b1;
        end
        if (res_count == 2'd2)
        begin
            res_second.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_STATUS;
            skip_reg    <= 1'b1;
            accum_reg   <= '0;
            status_reg  <= '0;
            key_reg     <= '0;
            tick_reg    <= '0;
            bcount_reg  <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            skip_reg    <= skip_next;
            accum_reg   <= accum_next;
            status_reg  <= status_next;
            key_reg     <= key_next;
            tick_reg    <= tick_next;
            bcount_reg  <= bcount_next;
            stopped_reg <= stopped_next;
        end
    end

    a_final_stops: assert property (@(posedge clk) disable iff (!rst_n)
        fire && final_byte |=> stopped_reg)
        else $error("final byte did not stop the parser");

    a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> res_count == 2'd0)
        else $error("stopped parser produced an event");

    a_two_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_count == 2'd2 |-> phase_reg == PH_ZERO2)
        else $error("two events outside the held zero status case");

    a_delta_silent: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DELTA |-> res_count == 2'd0)
        else $error("delta byte produced an event");

endmodule

/* rtl/core/mlep_res_fifo.sv */
// ----------------------------------------------------------------------------
// mlep_res_fifo
// Small result queue that takes up to two event records per cycle and
// hands out one per beat.
// ----------------------------------------------------------------------------
module mlep_res_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_count,
    input  mlep_pkg::event_t  push_first,
    input  mlep_pkg::event_t  push_second,
    output logic              has_space,
    input  logic              pop_ready,
    output logic              head_valid,
    output mlep_pkg::event_t  head
);
    import mlep_pkg::*;

    event_t                 entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]  count_reg,  count_next;
    logic [FIFO_PTR_W-1:0]  wr_ptr_second;
    logic                   pop;

    // Room is judged without the pop so that the input side never waits on
    // the output ready.
    assign has_space     = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign head_valid    = count_reg != '0;
    assign head          = entries_reg[rd_ptr_reg];
    assign pop           = head_valid && pop_ready;
    assign wr_ptr_second = wr_ptr_reg + FIFO_PTR_W'(1);
    assign wr_ptr_next   = wr_ptr_reg + FIFO_PTR_W'(push_count);
    assign rd_ptr_next   = pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
    assign count_next    = count_reg + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push_first;
        end
        if (push_count == 2'd2)
        begin
            entries_reg[wr_ptr_second] <= push_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push_count != 2'd0 |-> has_space)
        else $error("result pushed without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        push_count == 2'd0 && !pop |=> $stable(count_reg))
        else $error("result count moved without a push or pop");

endmodule

/* rtl/core/midi_like_event_parser.sv */
// ----------------------------------------------------------------------------
// midi_like_event_parser
// Byte-serial parser for a MIDI-like sequence: delta times, status bytes and
// data bytes in, decoded events with absolute tick times out.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (byte_valid/byte_ready) carries one file byte per beat with
//   final_byte set on the last one. Output channel (event_valid/event_ready)
//   carries one decoded event per beat; last_of_run marks the final event
//   caused by one input byte.
//   Throughput: one input byte per cycle while the result queue has room. A
//   byte yields zero, one or two events; two only when a zero status pair is
//   followed by an end of track or D status, and the second follows the first.
//   Path: an accepted byte is held in the input register, decoded in a single
//   pass into a four-entry result queue while the queue has room, and its
//   first event is offered as soon as it is written into the queue.
//   Reset clears the parse state to the status phase with the delta skipped,
//   the tick count to zero and empties the queue.
//   When the receiver stalls the queue fills, the decoder holds the byte in
//   its input register and byte_ready falls; nothing is dropped. After end of
//   track, data end, a D command or a final byte, bytes are still taken but
//   produce nothing until reset.
// ----------------------------------------------------------------------------
module midi_like_event_parser #(
    parameter int TICK_WIDTH = mlep_pkg::TICK_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_ready,
    input  logic [7:0]  data_byte,
    input  logic        final_byte,
    output logic        event_valid,
    input  logic        event_ready,
    output logic [2:0]  event_kind,
    output logic [3:0]  channel,
    output logic [7:0]  first_value,
    output logic [7:0]  second_value,
    output logic [31:0] tick_time,
    output logic [3:0]  event_bytes,
    output logic        last_of_run
);
    import mlep_pkg::*;

    logic       full_reg, full_next;
    logic [7:0] byte_reg;
    logic       final_reg;
    logic       fire;
    logic       has_space;
    logic       accept;
    event_t     res_first;
    event_t     res_second;
    logic [1:0] res_count;
    event_t     head;

    assign fire       = full_reg && has_space;
    assign byte_ready = !full_reg || fire;
    assign accept     = byte_valid && byte_ready;
    assign full_next  = accept || (full_reg && !fire);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg  <= data_byte;
            final_reg <= final_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    mlep_parser #(
        .TICK_WIDTH (TICK_WIDTH)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .data_byte  (byte_reg),
        .final_byte (final_reg),
        .res_first  (res_first),
        .res_second (res_second),
        .res_count  (res_count)
    );

    mlep_res_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (res_count),
        .push_first  (res_first),
        .push_second (res_second),
        .has_space   (has_space),
        .pop_ready   (event_ready),
        .head_valid  (event_valid),
        .head        (head)
    );

    assign event_kind   = head.kind;
    assign channel      = head.channel;
    assign first_value  = head.first_value;
    assign second_value = head.second_value;
    assign tick_time    = head.tick_time;
    assign event_bytes  = head.event_bytes;
    assign last_of_run  = head.last_of_run;

    a_no_push_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> res_count == 2'd0)
        else $error("events produced without a decoded byte");

    a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !has_space |=> full_reg && $stable(byte_reg))
        else $error("held byte lost while the queue was full");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !full_reg |-> byte_ready)
        else $error("input blocked with an empty input register");

endmodule

/* bench/midi_like_event_parser_tb.sv */
// ----------------------------------------------------------------------------
// midi_like_event_parser_tb
// Self-checking bench for the byte-serial event parser. The bench feeds one
// long sequence file through the valid/ready byte channel with random gaps on
// both sides. That file is a short directed table followed by random,
// mostly well-formed events, and one stopping tail at the end. It predicts
// every decoded event with its own parser model and compares each event beat
// field by field in order.
// ----------------------------------------------------------------------------
module midi_like_event_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mlep_pkg::*;

    localparam int STIM_TARGET     = 1850;
    localparam int DIR_ROWS        = 25;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int MAX_REPORTS     = 40;

    // Commands that carry one data byte but have no meaning of their own.
    localparam logic [3:0] CMD_UNKNOWN_A = 4'hA;
    localparam logic [3:0] CMD_UNKNOWN_B = 4'hB;

    typedef struct {
        phase_t      ph;
        logic        skip;
        logic [27:0] acc;
        logic [7:0]  status;
        logic [7:0]  key;
        logic [31:0] ticks;
        logic [3:0]  nbytes;
        logic        halted;
    } parser_state_t;

    typedef struct {
        logic [7:0] b;
        logic       fin;
        logic       typed;
        event_t     typed_ev;
    } byte_beat_t;

    typedef struct {
        logic [7:0] b;
        logic       typed;
        event_t     ev;
    } dir_row_t;

    typedef enum int {
        STOP_END_TRACK,
        STOP_D_COMMAND,
        STOP_DATA_END,
        STOP_ZERO_PAIR,
        STOP_FINAL_EVENT,
        STOP_FINAL_CUT
    } stop_t;

    logic        clk;
    logic        rst_n;
    logic        byte_valid;
    logic        byte_ready;
    logic [7:0]  data_byte;
    logic        final_byte;
    logic        event_valid;
    logic        event_ready;
    logic [2:0]  event_kind;
    logic [3:0]  channel;
    logic [7:0]  first_value;
    logic [7:0]  second_value;
    logic [31:0] tick_time;
    logic [3:0]  event_bytes;
    logic        last_of_run;

    byte_beat_t    file_bytes[$];
    event_t        pending_events[$];
    dir_row_t      directed_rows[DIR_ROWS];
    parser_state_t plan_st;
    parser_state_t track_st;
    int            fault_count;
    int            cycle_count;
    bit            hold_off_req;

    midi_like_event_parser #(
        .TICK_WIDTH(TICK_WIDTH_DEFAULT)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .data_byte(data_byte),
        .final_byte(final_byte),
        .event_valid(event_valid),
        .event_ready(event_ready),
        .event_kind(event_kind),
        .channel(channel),
        .first_value(first_value),
        .second_value(second_value),
        .tick_time(tick_time),
        .event_bytes(event_bytes),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic parser_state_t fresh_state();
        parser_state_t st;
        st.ph     = PH_STATUS;
        st.skip   = 1'b1;
        st.acc    = '0;
        st.status = '0;
        st.key    = '0;
        st.ticks  = '0;
        st.nbytes = '0;
        st.halted = 1'b0;
        return st;
    endfunction

    function automatic logic [3:0] bump(input logic [3:0] count);
        return (count == BYTES_MAX) ? count : count + 4'd1;
    endfunction

    function automatic event_t make_ev(input kind_t k, input logic [3:0] ch,
                                       input logic [7:0] v1, input logic [7:0] v2,
                                       input logic [31:0] t, input logic [3:0] nb,
                                       input logic lst);
        event_t e;
        e.kind         = k;
        e.channel      = ch;
        e.first_value  = v1;
        e.second_value = v2;
        e.tick_time    = t;
        e.event_bytes  = nb;
        e.last_of_run  = lst;
        return e;
    endfunction

    task automatic add_event(input parser_state_t st, input kind_t k, input logic [3:0] ch,
                             input logic [7:0] v1, input logic [7:0] v2,
                             inout int n, inout event_t ev0, inout event_t ev1);
        event_t e;
        e = make_ev(k, ch, v1, v2, st.ticks, st.nbytes, 1'b0);
        if (n == 0)
            ev0 = e;
        else
            ev1 = e;
        n++;
    endtask

    task automatic close_event(inout parser_state_t st);
        st.nbytes = '0;
        st.acc    = '0;
        st.ph     = st.skip ? PH_STATUS : PH_DELTA;
    endtask

    task automatic take_status(inout parser_state_t st, input logic [7:0] b,
                               inout int n, inout event_t ev0, inout event_t ev1);
        logic [7:0] s;
        s         = b | STATUS_FLAG;
        st.nbytes = bump(st.nbytes);
        st.skip   = ~b[7];
        if (b == 8'h00)
        begin
            st.status = STATUS_FLAG;
            st.ph     = PH_ZERO1;
        end
        else
        begin
            st.status = s;
            case (s[7:4])
                CMD_END_TRACK:
                begin
                    add_event(st, KIND_END_TRACK, s[3:0], 8'h00, 8'h00, n, ev0, ev1);
                    st.halted = 1'b1;
                end
                CMD_STOP_D:
                begin
                    add_event(st, KIND_UNKNOWN, s[3:0], 8'h00, 8'h00, n, ev0, ev1);
                    st.halted = 1'b1;
                end
                default:
                    st.ph = PH_DATA1;
            endcase
        end
    endtask

    // Advances the parser by one file byte and returns the events it completes.
    task automatic decode_byte(inout parser_state_t st, input logic [7:0] b, input logic fin,
                               output int n, output event_t ev0, output event_t ev1);
        n   = 0;
        ev0 = '0;
        ev1 = '0;
        if (!st.halted)
        begin
            case (st.ph)
                PH_DELTA:
                begin
                    st.nbytes = bump(st.nbytes);
                    st.acc    = {st.acc[20:0], b[6:0]};
                    if (!b[7])
                    begin
                        st.ticks = st.ticks + 32'(st.acc);
                        st.acc   = '0;
                        st.ph    = PH_STATUS;
                    end
                end
                PH_STATUS:
                    take_status(st, b, n, ev0, ev1);
                PH_DATA1:
                begin
                    st.nbytes = bump(st.nbytes);
                    case (st.status[7:4])
                        CMD_NOTE_OFF:
                        begin
                            add_event(st, KIND_NOTE_OFF, st.status[3:0], b, 8'h00, n, ev0, ev1);
                            close_event(st);
                        end
                        CMD_NOTE_ON:
                        begin
                            st.key = b;
                            st.ph  = PH_DATA2;
                        end
                        CMD_PROGRAM:
                        begin
                            add_event(st, KIND_PROGRAM, st.status[3:0], b, 8'h00, n, ev0, ev1);
                            close_event(st);
                        end
                        CMD_BEND:
                        begin
                            add_event(st, KIND_BEND, st.status[3:0], {1'b0, b[7:1]}, 8'h00,
                                      n, ev0, ev1);
                            close_event(st);
                        end
                        default:
                        begin
                            add_event(st, KIND_UNKNOWN, st.status[3:0], 8'h00, 8'h00,
                                      n, ev0, ev1);
                            close_event(st);
                        end
                    endcase
                end
                PH_DATA2:
                begin
                    st.nbytes = bump(st.nbytes);
                    add_event(st, KIND_NOTE_ON, st.status[3:0], st.key, b, n, ev0, ev1);
                    close_event(st);
                end
                PH_ZERO1:
                begin
                    st.nbytes = bump(st.nbytes);
                    if (b != 8'h00)
                    begin
                        add_event(st, KIND_NOTE_OFF, 4'h0, b, 8'h00, n, ev0, ev1);
                        close_event(st);
                    end
                    else
                        st.ph = PH_ZERO2;
                end
                PH_ZERO2:
                begin
                    if (b == 8'h00)
                    begin
                        st.nbytes = bump(st.nbytes);
                        add_event(st, KIND_DATA_END, 4'h0, 8'h00, 8'h00, n, ev0, ev1);
                        st.halted = 1'b1;
                    end
                    else
                    begin
                        // The zero pair closes as a note off and this byte opens the next
                        // event, so one byte may finish two events.
                        add_event(st, KIND_NOTE_OFF, 4'h0, 8'h00, 8'h00, n, ev0, ev1);
                        close_event(st);
                        take_status(st, b, n, ev0, ev1);
                    end
                end
                default:
                    st.ph = PH_STATUS;
            endcase
            if (fin)
                st.halted = 1'b1;
            if (n == 1)
                ev0.last_of_run = 1'b1;
            else if (n == 2)
                ev1.last_of_run = 1'b1;
        end
    endtask

    // ------------------------------------------------------------------------
    // Building the sequence file
    // ------------------------------------------------------------------------
    task automatic add_beat(input logic [7:0] b, input logic fin, input logic typed,
                            input event_t ev);
        byte_beat_t beat;
        int         n;
        event_t     e0;
        event_t     e1;
        beat.b        = b;
        beat.fin      = fin;
        beat.typed    = typed;
        beat.typed_ev = ev;
        file_bytes.push_back(beat);
        decode_byte(plan_st, b, fin, n, e0, e1);
    endtask

    task automatic add_byte(input logic [7:0] b, input logic fin);
        add_beat(b, fin, 1'b0, '0);
    endtask

    // Any byte at all, as long as it does not stop the parser.
    task automatic add_safe_byte();
        parser_state_t probe;
        logic [7:0]    b;
        int            n;
        event_t        e0;
        event_t        e1;
        do
        begin
            b     = 8'($urandom);
            probe = plan_st;
            decode_byte(probe, b, 1'b0, n, e0, e1);
        end
        while (probe.halted);
        add_byte(b, 1'b0);
    endtask

    // Finishes whatever event is open and writes a delta if one is due.
    task automatic gen_to_status();
        int         len;
        int         r;
        logic       cont;
        logic [6:0] grp;
        while (plan_st.ph != PH_DELTA && plan_st.ph != PH_STATUS)
            add_safe_byte();
        if (plan_st.ph == PH_DELTA)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                len = 1;
            else if (r < 60)
                len = 2;
            else if (r < 75)
                len = 3;
            else if (r < 95)
                len = 4;
            else
                len = $urandom_range(5, 15);
            for (int k = 0; k < len; k++)
            begin
                cont = (k != len - 1);
                grp  = 7'($urandom);
                add_byte({cont, grp}, 1'b0);
            end
        end
    endtask

    task automatic add_data(input logic [3:0] cmd, input logic fin_last);
        int         count;
        int         r;
        logic [7:0] v;
        count = (cmd == CMD_NOTE_ON) ? 2 : 1;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(0, 9);
            v = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
            add_byte(v, fin_last && (k == count - 1));
        end
    endtask

    task automatic gen_event(input logic fin_last);
        logic [3:0] cmd;
        logic [3:0] chan;
        logic [7:0] sb;
        int         r;
        gen_to_status();
        case ($urandom_range(0, 5))
            0: cmd = CMD_NOTE_OFF;
            1: cmd = CMD_NOTE_ON;
            2: cmd = CMD_UNKNOWN_A;
            3: cmd = CMD_UNKNOWN_B;
            4: cmd = CMD_PROGRAM;
            default: cmd = CMD_BEND;
        endcase
        chan = 4'($urandom);
        r    = $urandom_range(0, 99);
        if (r < 70)
        begin
            add_byte({cmd, chan}, 1'b0);
            add_data(cmd, fin_last);
        end
        else if (r < 84)
        begin
            // Status written without its top bit, which also turns the delta off.
            sb = {cmd, chan} & ~STATUS_FLAG;
            if (sb == 8'h00)
                sb = 8'h01;
            add_byte(sb, 1'b0);
            add_data(sb[7:4] | STATUS_FLAG[7:4], fin_last);
        end
        else if (r < 92)
        begin
            add_byte(8'h00, 1'b0);
            add_byte(8'($urandom_range(1, 255)), fin_last);
        end
        else
        begin
            add_byte(8'h00, 1'b0);
            add_byte(8'h00, 1'b0);
            do
                sb = 8'($urandom_range(1, 255));
            while (((sb | STATUS_FLAG) >> 4) == CMD_END_TRACK
                   || ((sb | STATUS_FLAG) >> 4) == CMD_STOP_D);
            add_byte(sb, 1'b0);
            add_data(sb[7:4] | STATUS_FLAG[7:4], fin_last);
        end
    endtask

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------
    task automatic report_fault(input string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_fault($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    always @(posedge clk)
    begin : watch_events
        event_t want;
        if (rst_n && event_valid && event_ready)
        begin
            if (pending_events.size() == 0)
                report_fault($sformatf("event of kind %0d with none pending", event_kind));
            else
            begin
                want = pending_events.pop_front();
                check_field("event_kind", event_kind, want.kind);
                check_field("channel", channel, want.channel);
                check_field("first_value", first_value, want.first_value);
                check_field("second_value", second_value, want.second_value);
                check_field("tick_time", tick_time, want.tick_time);
                check_field("event_bytes", event_bytes, want.event_bytes);
                check_field("last_of_run", last_of_run, want.last_of_run);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Event receiver
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int taken;
        int pause;
        bit calm;
        taken = 0;
        calm  = 1'b0;
        event_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (hold_off_req)
            begin
                // Long stall so that the result queue fills and input backs up.
                pause        = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            else
                pause = calm ? 0 : $urandom_range(0, 15);
            if (pause != 0)
            begin
                event_ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            event_ready <= 1'b1;
            do
                @(posedge clk);
            while (!event_valid);
            taken++;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timed out after %0d cycles", cycle_count);
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus, byte sender and end of run
    // ------------------------------------------------------------------------
    initial
    begin : main_flow
        stop_t      stop_kind;
        byte_beat_t beat;
        event_t     e0;
        event_t     e1;
        int         n;
        int         gap;
        bit         calm;
        logic [3:0] chan;
        logic [7:0] sb;

        rst_n       <= 1'b0;
        byte_valid  <= 1'b0;
        data_byte   <= 8'h00;
        final_byte  <= 1'b0;
        fault_count  = 0;
        hold_off_req = 1'b0;
        plan_st      = fresh_state();
        track_st     = fresh_state();

        directed_rows = '{
            // After reset the delta is skipped: note on, key 0, full velocity.
            '{8'h90, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h7F, 1'b1, make_ev(KIND_NOTE_ON, 4'h0, 8'h00, 8'h7F, 32'h0, 4'd3, 1'b1)},
            // Largest four-byte delta, then note off on the top channel.
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'hFF, 1'b0, '0},
            '{8'h7F, 1'b0, '0},
            '{8'h8F, 1'b0, '0},
            '{8'hFF, 1'b1, make_ev(KIND_NOTE_OFF, 4'hF, 8'hFF, 8'h00, 32'h0FFFFFFF, 4'd6, 1'b1)},
            // Status without its top bit, so the next delta is skipped.
            '{8'h00, 1'b0, '0},
            '{8'h0A, 1'b0, '0},
            '{8'h80, 1'b0, '0},
            '{8'hC3, 1'b0, '0},
            '{8'h55, 1'b1, make_ev(KIND_PROGRAM, 4'h3, 8'h55, 8'h00, 32'h0FFFFFFF, 4'd2, 1'b1)},
            '{8'h00, 1'b0, '0},
            '{8'hE7, 1'b0, '0},
            '{8'hFF, 1'b1, make_ev(KIND_BEND, 4'h7, 8'h7F, 8'h00, 32'h0FFFFFFF, 4'd3, 1'b1)},
            '{8'h00, 1'b0, '0},
            '{8'hA1, 1'b0, '0},
            '{8'h12, 1'b0, '0},
            // Zero status pair followed by a status byte.
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'h00, 1'b0, '0},
            '{8'hB2, 1'b0, '0},
            '{8'h34, 1'b0, '0}
        };
        foreach (directed_rows[r])
            add_beat(directed_rows[r].b, 1'b0, directed_rows[r].typed, directed_rows[r].ev);

        while (file_bytes.size() < STIM_TARGET)
        begin
            if ($urandom_range(0, 9) == 0)
                add_safe_byte();
            else
                gen_event(1'b0);
        end

        // Only one stop is possible per run, as reset is never asserted again.
        stop_kind = stop_t'($urandom_range(0, 5));
        chan      = 4'($urandom);
        case (stop_kind)
            STOP_END_TRACK:
            begin
                gen_to_status();
                sb = {CMD_END_TRACK, chan};
                add_byte($urandom_range(0, 1) ? sb : (sb & ~STATUS_FLAG), 1'b0);
            end
            STOP_D_COMMAND:
            begin
                gen_to_status();
                sb = {CMD_STOP_D, chan};
                add_byte($urandom_range(0, 1) ? sb : (sb & ~STATUS_FLAG), 1'b0);
            end
            STOP_DATA_END:
            begin
                gen_to_status();
                repeat (3) add_byte(8'h00, 1'b0);
            end
            STOP_ZERO_PAIR:
            begin
                gen_to_status();
                add_byte(8'h00, 1'b0);
                add_byte(8'h00, 1'b0);
                sb = {$urandom_range(0, 1) ? CMD_END_TRACK : CMD_STOP_D, chan};
                add_byte($urandom_range(0, 1) ? sb : (sb & ~STATUS_FLAG), 1'b0);
            end
            STOP_FINAL_EVENT:
                gen_event(1'b1);
            default:
            begin
                // The file ends inside a note on, which is then dropped.
                gen_to_status();
                add_byte({CMD_NOTE_ON, chan}, 1'b0);
                add_byte(8'($urandom), 1'b1);
            end
        endcase
        repeat ($urandom_range(2, 8)) add_byte(8'($urandom), 1'($urandom));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        calm = 1'b0;
        for (int i = 0; i < file_bytes.size(); i++)
        begin
            beat = file_bytes[i];
            if (i % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i == file_bytes.size() / 2)
                hold_off_req = 1'b1;
            gap = calm ? 0 : $urandom_range(0, 15);
            if (gap != 0)
            begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            byte_valid <= 1'b1;
            data_byte  <= beat.b;
            final_byte <= beat.fin;
            do
                @(posedge clk);
            while (!byte_ready);
            // Beat accepted at this edge.
            decode_byte(track_st, beat.b, beat.fin, n, e0, e1);
            if (beat.typed)
                e0 = beat.typed_ev;
            if (n > 0)
                pending_events.push_back(e0);
            if (n > 1)
                pending_events.push_back(e1);
        end
        byte_valid <= 1'b0;

        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
